FILE: rtl/core/b64e_pkg.sv
// b64e_pkg: shared types, codes and the character mapping function for the base64 stream encoder.
// Used by b64e_front, b64e_queue and b64e_back; has no dependencies of its own.

package b64e_pkg;

    // padding character '='
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // position inside the current 3-byte group
    localparam logic [1:0] PH_ZERO = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_TWO  = 2'd2;

    // one queued job: up to four characters for one input byte
    typedef struct packed {
        logic [3:0][7:0] chars;     // character k in chars[k]
        logic [1:0]      last_idx;  // index of the final character of the job
        logic            eom;       // job closes the message
    } cmd_t;

    // map a 6-bit code onto the standard alphabet
    function automatic logic [7:0] enc(input logic [5:0] code);
        logic [7:0] c8;
        c8 = {2'b00, code};
        if (code < 6'd26) begin
            enc = c8 + 8'h41;
        end else if (code < 6'd52) begin
            enc = c8 + 8'h47;  // 'a' - 26
        end else if (code < 6'd62) begin
            enc = c8 - 8'h04;  // '0' - 52
        end else if (code == 6'd62) begin
            enc = 8'h2B;
        end else begin
            enc = 8'h2F;
        end
    endfunction

endpackage

FILE: rtl/core/b64e_front.sv
// b64e_front: accepts raw bytes, tracks the group position and builds one job per byte.
// Depends on b64e_pkg.

module b64e_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // data_byte
    input  logic              s_tlast,   // end_of_message
    input  logic              q_full,
    output logic              q_push,
    output b64e_pkg::cmd_t    q_cmd
);

    logic [3:0] left_reg;
    logic [3:0] left_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [3:0] grp_left;
    logic [1:0] grp_phase;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // split the byte into characters, then add flush and padding on the last byte
    always_comb begin
        q_cmd          = '0;
        q_cmd.eom      = s_tlast;
        grp_left       = 4'd0;
        grp_phase      = b64e_pkg::PH_ZERO;
        unique case (phase_reg)
            b64e_pkg::PH_ONE: begin
                q_cmd.chars[0] = b64e_pkg::enc({left_reg[1:0], s_tdata[7:4]});
                q_cmd.last_idx = 2'd0;
                grp_left       = s_tdata[3:0];
                grp_phase      = b64e_pkg::PH_TWO;
            end
            b64e_pkg::PH_TWO: begin
                q_cmd.chars[0] = b64e_pkg::enc({left_reg, s_tdata[7:6]});
                q_cmd.chars[1] = b64e_pkg::enc(s_tdata[5:0]);
                q_cmd.last_idx = 2'd1;
                grp_left       = 4'd0;
                grp_phase      = b64e_pkg::PH_ZERO;
            end
            default: begin
                // unreachable phase three behaves as phase zero
                q_cmd.chars[0] = b64e_pkg::enc(s_tdata[7:2]);
                q_cmd.last_idx = 2'd0;
                grp_left       = {2'b00, s_tdata[1:0]};
                grp_phase      = b64e_pkg::PH_ONE;
            end
        endcase
        if (s_tlast) begin
            unique case (grp_phase)
                b64e_pkg::PH_ONE: begin
                    q_cmd.chars[1] = b64e_pkg::enc({grp_left[1:0], 4'b0000});
                    q_cmd.chars[2] = b64e_pkg::PAD_CHAR;
                    q_cmd.chars[3] = b64e_pkg::PAD_CHAR;
                    q_cmd.last_idx = 2'd3;
                end
                b64e_pkg::PH_TWO: begin
                    q_cmd.chars[1] = b64e_pkg::enc({grp_left, 2'b00});
                    q_cmd.chars[2] = b64e_pkg::PAD_CHAR;
                    q_cmd.last_idx = 2'd2;
                end
                default: begin
                    // group complete, nothing to flush
                end
            endcase
        end
        left_next  = s_tlast ? 4'd0 : grp_left;
        phase_next = s_tlast ? b64e_pkg::PH_ZERO : grp_phase;
    end

    // group state advances on every accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg  <= 4'd0;
            phase_reg <= b64e_pkg::PH_ZERO;
        end else if (q_push) begin
            left_reg  <= left_next;
            phase_reg <= phase_next;
        end
    end

endmodule

FILE: rtl/core/b64e_queue.sv
// b64e_queue: short first-in first-out queue of jobs between front and back.
// Depends on b64e_pkg.

module b64e_queue #(
    parameter int DEPTH = 2  // 2 to 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  b64e_pkg::cmd_t    push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output b64e_pkg::cmd_t    head_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64e_pkg::cmd_t     slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // storage slots
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/b64e_back.sv
// b64e_back: steps through the characters of the head job and drives the output register.
// Depends on b64e_pkg.

module b64e_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  b64e_pkg::cmd_t    head_cmd,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // out_char
    output logic              m_tlast    // last_char
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       load;
    logic       job_done;

    // output register takes a new character when empty or being drained
    assign load     = head_valid && (!valid_reg || m_tready);
    assign job_done = (idx_reg == head_cmd.last_idx);
    assign pop      = load && job_done;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    // character sequencer and valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg   <= job_done ? 2'd0 : idx_reg + 2'd1;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= head_cmd.chars[idx_reg];
            last_reg <= head_cmd.eom && job_done;
        end
    end

endmodule

FILE: rtl/core/base64_stream_encoder.sv
// base64_stream_encoder: top level of the streaming base64 encoder with '=' padding.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
// Input channel (s_): one raw byte per transfer in s_tdata; s_tlast marks the
// final byte of a message and makes the block flush the partial character and
// append '=' padding, so every message encodes to a multiple of four characters.
// Output channel (m_): one ASCII character per transfer in m_tdata; m_tlast is
// high on the final character of each encoded message.
// The first character of a byte passes through the job queue and then the
// output register before it appears on m_tvalid. A byte yields 1 or 2
// characters (up to 4 on the last byte), and the output register issues one
// character per cycle while m_tready is high; 3 bytes yield 4 characters.
// The front accepts a byte every cycle while the job queue has room
// (QUEUE_DEPTH jobs), also while a finished character waits on m_tready.
// Reset (aresetn low, synchronous) empties the queue, drops m_tvalid and
// returns to the start of a 3-byte group. A stalled receiver holds m_tdata and
// m_tlast; the queue then fills and s_tready falls.

module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = 2  // 2 to 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic        m_tlast    // last_char
);

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    b64e_pkg::cmd_t    push_cmd;
    b64e_pkg::cmd_t    head_cmd;

    // byte intake and classification
    b64e_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // job queue
    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    // character output
    b64e_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

FILE: rtl/core/b64e_checker.sv
// b64e_checker: port-level assertions for base64_stream_encoder, attached by bind.
// Depends only on the top level's ports.

module b64e_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // a stalled character holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output transfer changed");

    // reset empties the output and opens the input
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

    // only alphabet characters or padding leave the block
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata >= 8'h41 && m_tdata <= 8'h5A)
                  || (m_tdata >= 8'h61 && m_tdata <= 8'h7A)
                  || (m_tdata >= 8'h30 && m_tdata <= 8'h39)
                  || m_tdata == 8'h2B || m_tdata == 8'h2F || m_tdata == 8'h3D)
        else $error("character outside the base64 alphabet");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (.*);
